/* sv/assert_macros.svh */
// Assertion macros shared by the modular exponentiation modules.
// The macros expect a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mexp_pkg.sv */
// Package for the modular exponentiation unit: widths, codes and the
// command and status types shared by the controller and datapath.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int MOD_BITS  = 31;
  localparam int EXP_BITS  = 63;
  localparam int BASE_W    = 63;
  localparam int DIV_W     = 64;
  localparam int RED_STEPS = DIV_W / 2;
  localparam int CNT_W     = $clog2(RED_STEPS);
  localparam int REM_W     = MOD_BITS + 1;
  localparam int ADDR_W    = 2;
  localparam int DATA_W    = 32;

  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);
  localparam logic [ADDR_W-1:0]   ADDR_MODULUS  = ADDR_W'(0);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_CHECK,
    S_MUL_ACC,
    S_MUL_SQ,
    S_DONE
  } mexp_state_t;

  typedef enum logic {
    TGT_BASE,
    TGT_ACC
  } mexp_tgt_t;

  typedef struct packed {
    logic      load_item;
    logic      load_prod;
    mexp_tgt_t tgt;
    logic      shift_exp;
    logic      step_red;
  } mexp_cmd_t;

  typedef struct packed {
    logic      exp_zero;
    logic      exp_lsb;
    logic      exp_rest_zero;
    logic      red_last;
    mexp_tgt_t tgt;
  } mexp_sts_t;

endpackage

/* sv/mexp_dp.sv */
// Datapath of the modular exponentiation unit: operand registers, the shared
// multiplier and the two-bit-per-cycle remainder unit. Depends on mexp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mexp_dp import mexp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  mexp_cmd_t           cmd,
  output mexp_sts_t           sts,
  input  logic [MOD_BITS-1:0] modulus,
  input  logic [BASE_W-1:0]   in_base,
  input  logic [BASE_W-1:0]   in_exponent,
  output logic [MOD_BITS-1:0] result
);

  logic [MOD_BITS-1:0]   m_r;
  logic [EXP_BITS-1:0]   e_r;
  logic [MOD_BITS-1:0]   b_r;
  logic [MOD_BITS-1:0]   acc_r;
  logic [DIV_W-1:0]      div_r;
  logic [REM_W-1:0]      rem_r;
  logic [CNT_W-1:0]      cnt_r;
  mexp_tgt_t             tgt_r;

  logic [MOD_BITS-1:0]   mul_a;
  logic [2*MOD_BITS-1:0] prod;
  logic [REM_W:0]        m_ext;
  logic [REM_W:0]        t1;
  logic [REM_W:0]        r1;
  logic [REM_W:0]        t2;
  logic [REM_W:0]        r2;
  logic                  red_last;

  assign mul_a = (cmd.tgt == TGT_ACC) ? acc_r : b_r;
  assign prod  = mul_a * b_r;

  assign m_ext = (REM_W + 1)'(m_r);
  assign t1    = {rem_r, div_r[DIV_W-1]};
  assign r1    = (t1 >= m_ext) ? (t1 - m_ext) : t1;
  assign t2    = {r1[REM_W-1:0], div_r[DIV_W-2]};
  assign r2    = (t2 >= m_ext) ? (t2 - m_ext) : t2;

  assign red_last = (cnt_r == CNT_W'(RED_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load_item || cmd.load_prod) begin
      cnt_r <= '0;
    end else if (cmd.step_red) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      m_r   <= (modulus == '0) ? MOD_BITS'(1) : modulus;
      e_r   <= in_exponent[EXP_BITS-1:0];
      acc_r <= MOD_BITS'(1);
      div_r <= DIV_W'(in_base);
      rem_r <= '0;
      tgt_r <= TGT_BASE;
    end else if (cmd.load_prod) begin
      div_r <= DIV_W'(prod);
      rem_r <= '0;
      tgt_r <= cmd.tgt;
      if (cmd.shift_exp) begin
        e_r <= e_r >> 1;
      end
    end else if (cmd.step_red) begin
      div_r <= div_r << 2;
      rem_r <= r2[REM_W-1:0];
      if (red_last) begin
        if (tgt_r == TGT_ACC) begin
          acc_r <= r2[MOD_BITS-1:0];
        end else begin
          b_r <= r2[MOD_BITS-1:0];
        end
      end
    end
  end

  assign sts.exp_zero      = (e_r == '0);
  assign sts.exp_lsb       = e_r[0];
  assign sts.exp_rest_zero = ((e_r >> 1) == '0);
  assign sts.red_last      = red_last;
  assign sts.tgt           = tgt_r;

  assign result = acc_r;

  `ASSERT_IMPL(a_rem_below_mod, cnt_r != '0, rem_r < REM_W'(m_r), "remainder not below modulus")
  `ASSERT_IMPL(a_step_alone, cmd.step_red, !cmd.load_prod && !cmd.load_item, "step during load")

endmodule

/* sv/mexp_ctrl.sv */
// Controller of the modular exponentiation unit: sequences the base
// reduction and the square-and-multiply steps. Depends on mexp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mexp_ctrl import mexp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      out_free,
  output logic      emit,
  input  mexp_sts_t sts,
  output mexp_cmd_t cmd
);

  mexp_state_t state_r;
  mexp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (sts.red_last) begin
          if (sts.tgt == TGT_ACC) begin
            state_nxt = sts.exp_rest_zero ? S_DONE : S_MUL_SQ;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.exp_zero) begin
          state_nxt = S_DONE;
        end else if (sts.exp_lsb) begin
          state_nxt = S_MUL_ACC;
        end else begin
          state_nxt = S_MUL_SQ;
        end
      end
      S_MUL_ACC: state_nxt = S_RED;
      S_MUL_SQ:  state_nxt = S_RED;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.tgt  = TGT_BASE;
    in_stall = 1'b1;
    emit     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      S_RED: begin
        cmd.step_red = 1'b1;
      end
      S_CHECK: begin
      end
      S_MUL_ACC: begin
        cmd.load_prod = 1'b1;
        cmd.tgt       = TGT_ACC;
      end
      S_MUL_SQ: begin
        cmd.load_prod = 1'b1;
        cmd.shift_exp = 1'b1;
      end
      S_DONE: begin
        emit = out_free;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_NEXT(a_load_starts_red, cmd.load_item, state_r == S_RED, "item load did not start reduction")
  `ASSERT_IMPL(a_emit_when_free, emit, out_free && in_stall, "result emitted into a full slot")

endmodule

/* sv/modular_exponentiation_unit.sv */
// Top level of the modular exponentiation unit: configuration register,
// output register, controller and datapath. Depends on mexp_pkg.
//
// The block computes base to the exponent modulo the modulus register,
// using right-to-left binary square-and-multiply. Each input transfer
// (in_valid high, in_stall low) carries in_base and in_exponent; each
// yields exactly one output transfer of out_result.
// Items are processed one at a time. The base is first reduced, then each
// exponent bit up to the highest set one takes a decision state, a multiply
// into the result when it is set and a squaring of the base when a higher
// bit is set. Each multiply uses the shared 31x31 multiplier and then the
// remainder unit, which retires two product bits per cycle.
// An exponent of zero returns 1. A modulus of zero acts as a modulus of 1.
// The modulus is to be written over the APB port at address 0 only while
// idle; the block itself does not enforce this.
// Reset sets the modulus to 1000000007 and empties the output register.
// A finished result waits in the output register while out_stall is high;
// the next item is taken only once that result can be handed over.
`timescale 1ns / 1ps

module modular_exponentiation_unit import mexp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BASE_W-1:0]   in_base,
  input  logic [BASE_W-1:0]   in_exponent,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MOD_BITS-1:0] out_result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [MOD_BITS-1:0] modulus_r;
  logic                out_valid_r;
  logic [MOD_BITS-1:0] out_result_r;
  logic                out_free;
  logic                emit;
  logic [MOD_BITS-1:0] result;
  mexp_cmd_t           cmd;
  mexp_sts_t           sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_MODULUS)) begin
      modulus_r <= pwdata[MOD_BITS-1:0];
    end
  end

  assign prdata = (paddr == ADDR_MODULUS) ? DATA_W'(modulus_r) : '0;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_result_r <= result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .emit     (emit),
    .sts      (sts),
    .cmd      (cmd)
  );

  mexp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .modulus     (modulus_r),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .result      (result)
  );

endmodule
